/* design/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, constants and register indexes for the RGB565 HSL color
// classifier and its pipelined divider.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // divider geometry: 16-bit dividend, 9-bit divisor, 8-bit quotient
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 9;
  localparam int DIV_QUO_W = 8;

  localparam logic [7:0]  HUE_FULL       = 8'd240;
  localparam logic [7:0]  HUE_OFS_RED    = 8'd0;
  localparam logic [7:0]  HUE_OFS_GREEN  = 8'd80;
  localparam logic [7:0]  HUE_OFS_BLUE   = 8'd160;
  localparam logic [15:0] HUE_STEP       = 16'd40;
  localparam logic [15:0] SAT_SCALE      = 16'd240;
  localparam logic [8:0]  SAT_FOLD       = 9'd511;
  localparam logic [16:0] HUE_WRAP       = 17'd65295;
  // lightness = floor(sum * 8 / 17); divide by 17 as (x + 1) * 3855 >> 16
  localparam logic [23:0] LIGHT_RECIP    = 24'd3855;
  // lightness <= 120 exactly when sum <= 257, lightness == 0 when sum <= 2
  localparam logic [8:0]  SUM_SAT_SPLIT  = 9'd257;
  localparam logic [8:0]  SUM_LIGHT_ZERO = 9'd2;

  typedef enum logic [2:0] {
    REG_HUE_LOW    = 3'd0,
    REG_HUE_HIGH   = 3'd1,
    REG_SAT_LOW    = 3'd2,
    REG_SAT_HIGH   = 3'd3,
    REG_LIGHT_LOW  = 3'd4,
    REG_LIGHT_HIGH = 3'd5
  } cfg_reg_t;

endpackage

/* design/rgb565_hsl_color_classifier.sv */
// ----------------------------------------------------------------------------
// rgb565_hsl_color_classifier
// 12 register stages, the first one loaded at the accepting edge. Throughput:
// one word per cycle; busy is always low, the pipeline never stalls. The hue
// and saturation divides run in an 8-stage bit-per-stage divider, which sets
// the depth. Synchronous active-low reset clears the valid pipeline and loads
// the threshold registers with their defaults.
// ----------------------------------------------------------------------------
module rgb565_hsl_color_classifier
  import rhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_pixel,
  output logic        out_valid,
  output logic [7:0]  out_hue,
  output logic [7:0]  out_lightness,
  output logic [7:0]  out_saturation,
  output logic        out_match,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef struct packed {
    logic [7:0] light;
    logic [7:0] hue_ofs;
    logic       hue_neg;
    logic       grey;
    logic       sat_zero;
  } side_t;

  // ---------------- configuration ----------------
  logic [15:0] hue_low_r, hue_high_r;
  logic [7:0]  sat_low_r, sat_high_r, light_low_r, light_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r    <= 16'd65496;
      hue_high_r   <= 16'd40;
      sat_low_r    <= 8'd90;
      sat_high_r   <= 8'd180;
      light_low_r  <= 8'd0;
      light_high_r <= 8'd80;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HUE_LOW:    hue_low_r    <= cfg_data;
        REG_HUE_HIGH:   hue_high_r   <= cfg_data;
        REG_SAT_LOW:    sat_low_r    <= cfg_data[7:0];
        REG_SAT_HIGH:   sat_high_r   <= cfg_data[7:0];
        REG_LIGHT_LOW:  light_low_r  <= cfg_data[7:0];
        REG_LIGHT_HIGH: light_high_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: expand, max / min ----------------
  logic       s1_vld_r;
  logic [7:0] s1_r_r, s1_g_r, s1_b_r, s1_mx_r, s1_mn_r;
  logic [7:0] r_nxt, g_nxt, b_nxt, mx_nxt, mn_nxt;

  always_comb begin
    r_nxt  = {in_pixel[15:11], 3'b000};
    g_nxt  = {in_pixel[10:5], 2'b00};
    b_nxt  = {in_pixel[4:0], 3'b000};
    mx_nxt = r_nxt;
    if (g_nxt > mx_nxt) mx_nxt = g_nxt;
    if (b_nxt > mx_nxt) mx_nxt = b_nxt;
    mn_nxt = r_nxt;
    if (g_nxt < mn_nxt) mn_nxt = g_nxt;
    if (b_nxt < mn_nxt) mn_nxt = b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_r_r  <= r_nxt;
    s1_g_r  <= g_nxt;
    s1_b_r  <= b_nxt;
    s1_mx_r <= mx_nxt;
    s1_mn_r <= mn_nxt;
  end

  // ---------------- stage 2: numerators, divisors, lightness ----------------
  logic                 s2_vld_r;
  logic [DIV_NUM_W-1:0] s2_hnum_r, s2_snum_r;
  logic [DIV_DEN_W-1:0] s2_hden_r, s2_sden_r;
  side_t                s2_side_r;

  logic [7:0]  dif;
  logic [8:0]  sum;
  logic [8:0]  hdiff;
  logic [7:0]  hmag;
  logic [23:0] light_prod;
  logic [DIV_NUM_W-1:0] hnum_nxt, snum_nxt;
  logic [DIV_DEN_W-1:0] hden_nxt, sden_nxt;
  side_t       side_nxt;

  always_comb begin
    dif = s1_mx_r - s1_mn_r;
    sum = {1'b0, s1_mx_r} + {1'b0, s1_mn_r};
    side_nxt = '0;
    // red wins ties over green, green over blue
    if (s1_mx_r == s1_r_r) begin
      hdiff = {1'b0, s1_g_r} - {1'b0, s1_b_r};
      side_nxt.hue_ofs = (s1_mn_r == s1_b_r) ? HUE_OFS_RED : HUE_FULL;
    end else if (s1_mx_r == s1_g_r) begin
      hdiff = {1'b0, s1_b_r} - {1'b0, s1_r_r};
      side_nxt.hue_ofs = HUE_OFS_GREEN;
    end else begin
      hdiff = {1'b0, s1_r_r} - {1'b0, s1_g_r};
      side_nxt.hue_ofs = HUE_OFS_BLUE;
    end
    side_nxt.hue_neg = hdiff[8];
    hmag       = hdiff[8] ? 8'(-hdiff) : hdiff[7:0];
    hnum_nxt   = DIV_NUM_W'(hmag) * HUE_STEP;
    hden_nxt   = DIV_DEN_W'(dif);
    snum_nxt   = DIV_NUM_W'(dif) * SAT_SCALE;
    sden_nxt   = (sum <= SUM_SAT_SPLIT) ? sum : SAT_FOLD - sum;
    light_prod = 24'({sum, 3'b001}) * LIGHT_RECIP;
    side_nxt.light    = light_prod[23:16];
    side_nxt.grey     = (dif == 8'd0);
    side_nxt.sat_zero = (sum <= SUM_LIGHT_ZERO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_hnum_r <= hnum_nxt;
    s2_hden_r <= hden_nxt;
    s2_snum_r <= snum_nxt;
    s2_sden_r <= sden_nxt;
    s2_side_r <= side_nxt;
  end

  // ---------------- stages 3..10: dividers ----------------
  logic                 hdiv_vld, sdiv_vld;
  logic [DIV_QUO_W-1:0] hquo, squo;
  side_t                side_r [DIV_QUO_W];

  rhc_div u_hue_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_num    (s2_hnum_r),
    .in_den    (s2_hden_r),
    .out_valid (hdiv_vld),
    .out_quo   (hquo)
  );

  rhc_div u_sat_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_num    (s2_snum_r),
    .in_den    (s2_sden_r),
    .out_valid (sdiv_vld),
    .out_quo   (squo)
  );

  always_ff @(posedge clk) begin
    side_r[0] <= s2_side_r;
    for (int k = 1; k < DIV_QUO_W; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // ---------------- stage 11: hue / saturation ----------------
  side_t      side_out;
  logic       s11_vld_r;
  logic [7:0] s11_hue_r, s11_sat_r, s11_light_r;
  logic [7:0] hue_nxt, sat_nxt;

  assign side_out = side_r[DIV_QUO_W-1];

  always_comb begin
    if (side_out.grey) begin
      hue_nxt = 8'd0;
    end else if (side_out.hue_neg) begin
      hue_nxt = side_out.hue_ofs - hquo;
    end else begin
      hue_nxt = side_out.hue_ofs + hquo;
    end
    sat_nxt = (side_out.grey || side_out.sat_zero) ? 8'd0 : squo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_vld_r <= 1'b0;
    end else begin
      s11_vld_r <= hdiv_vld && sdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    s11_hue_r   <= hue_nxt;
    s11_sat_r   <= sat_nxt;
    s11_light_r <= side_out.light;
  end

  // ---------------- stage 12: threshold test, output word ----------------
  logic        out_valid_r, out_match_r;
  logic [7:0]  out_hue_r, out_light_r, out_sat_r;
  logic        match_nxt;
  logic [16:0] hue_x;
  logic        hue_inside, hue_wrap_lo, hue_wrap_hi;

  always_comb begin
    hue_x      = 17'(s11_hue_r);
    hue_inside = (hue_x > 17'(hue_low_r)) && (hue_x < 17'(hue_high_r));
    // wrapped low bound: hue_low holds a negative bound offset by 65295
    hue_wrap_lo = (hue_high_r < hue_low_r) &&
                  ((hue_x < 17'(hue_high_r)) || (hue_x + HUE_WRAP > 17'(hue_low_r)));
    // wrapped high bound above the hue scale
    hue_wrap_hi = !(hue_high_r < hue_low_r) && (hue_high_r > 16'(HUE_FULL)) &&
                  ((hue_x > 17'(hue_high_r)) ||
                   (hue_x + 17'(HUE_FULL) < 17'(hue_high_r)));
    match_nxt = (s11_light_r > light_low_r) && (s11_light_r < light_high_r) &&
                (s11_sat_r > sat_low_r) && (s11_sat_r < sat_high_r) &&
                (hue_inside || hue_wrap_lo || hue_wrap_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s11_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hue_r   <= s11_hue_r;
    out_light_r <= s11_light_r;
    out_sat_r   <= s11_sat_r;
    out_match_r <= match_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_lightness  = out_light_r;
  assign out_saturation = out_sat_r;
  assign out_match      = out_match_r;

  // ---------------- assertions ----------------
  a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    hdiv_vld == sdiv_vld)
    else $error("hue and saturation dividers out of step");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue <= HUE_FULL) && (out_saturation <= HUE_FULL) &&
                  (out_lightness <= HUE_FULL))
    else $error("result word off the 0..240 scale");

  a_match_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match |->
      (out_lightness > light_low_r) && (out_lightness < light_high_r) &&
      (out_saturation > sat_low_r) && (out_saturation < sat_high_r))
    else $error("match flagged outside lightness or saturation bounds");

  a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s11_vld_r && $past(side_out.grey) |-> (s11_hue_r == 8'd0) && (s11_sat_r == 8'd0))
    else $error("grey pixel with nonzero hue or saturation");

endmodule

/* design/rhc_div.sv */
// ----------------------------------------------------------------------------
// rhc_div
// Restoring unsigned divider, one quotient bit per register stage. Accepts a
// new word every cycle.
// The caller guarantees the quotient fits in DIV_QUO_W bits.
// ----------------------------------------------------------------------------
module rhc_div
  import rhc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [DIV_NUM_W-1:0] in_num,
  input  logic [DIV_DEN_W-1:0] in_den,
  output logic                 out_valid,
  output logic [DIV_QUO_W-1:0] out_quo
);

  localparam int REM_W = DIV_NUM_W + 1;

  logic [DIV_NUM_W-1:0] rem_r [DIV_QUO_W-1];
  logic [DIV_DEN_W-1:0] den_r [DIV_QUO_W-1];
  logic [DIV_QUO_W-1:0] quo_r [DIV_QUO_W];
  logic                 vld_r [DIV_QUO_W];

  for (genvar j = 0; j < DIV_QUO_W; j++) begin : g_stage
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_QUO_W-1:0] quo_in;
    logic                 vld_in;
    logic [REM_W-1:0]     trial;
    logic                 take;
    logic [DIV_NUM_W-1:0] rem_nxt;
    logic [DIV_QUO_W-1:0] quo_nxt;

    if (j == 0) begin : g_first
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
      assign vld_in = vld_r[j-1];
    end

    assign trial   = {{(REM_W-DIV_DEN_W){1'b0}}, den_in} << (DIV_QUO_W - 1 - j);
    assign take    = {1'b0, rem_in} >= trial;
    assign rem_nxt = take ? DIV_NUM_W'({1'b0, rem_in} - trial) : rem_in;
    assign quo_nxt = {quo_in[DIV_QUO_W-2:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      quo_r[j] <= quo_nxt;
    end

    // last stage needs no remainder or divisor
    if (j < DIV_QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_in;
      end
    end
  end

  assign out_valid = vld_r[DIV_QUO_W-1];
  assign out_quo   = quo_r[DIV_QUO_W-1];

endmodule

/* verif/rgb565_hsl_color_classifier_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb565_hsl_color_classifier_test
// Streams RGB565 pixels through the classifier under a series of threshold
// settings (reset defaults, empty ranges, wide open, hue wrap, random) and
// checks hue, lightness, saturation and the match flag of every output word
// against an in-bench integer HSL model.
// ----------------------------------------------------------------------------
module rgb565_hsl_color_classifier_test;
  import rhc_pkg::*;

  localparam int PIPE_LATENCY   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;
  // indexes past the last threshold register; writes there are dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int N_DIRECTED = 18;
  // black, white, primaries, yellow, magenta, cyan, greys, orange, azure,
  // lightness at 120 and just above, dark pixels, alternating bits
  localparam logic [N_DIRECTED*16-1:0] DIRECTED_PX = {
    16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hFFE0,
    16'hF81F, 16'h07FF, 16'h8410, 16'hC618, 16'hFBE0, 16'h03FF,
    16'hFA01, 16'hF862, 16'h0801, 16'h0020, 16'hAAAA, 16'h5555
  };

  typedef struct packed {
    logic [15:0] pixel;
    logic [7:0]  hue;
    logic [7:0]  lightness;
    logic [7:0]  saturation;
    logic        in_range;
  } hsl_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_pixel = '0;
  logic        out_valid;
  logic [7:0]  out_hue;
  logic [7:0]  out_lightness;
  logic [7:0]  out_saturation;
  logic        out_match;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // threshold copy, reset values
  logic [15:0] hue_low_q = 16'd65496;
  logic [15:0] hue_high_q = 16'd40;
  logic [7:0]  sat_low_q = 8'd90;
  logic [7:0]  sat_high_q = 8'd180;
  logic [7:0]  light_low_q = 8'd0;
  logic [7:0]  light_high_q = 8'd80;

  logic [15:0] pixel_q[$];
  hsl_word_t   hsl_expected_q[$];
  logic        in_took = 1'b0;
  int          idle_pct = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  rgb565_hsl_color_classifier u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_lightness  (out_lightness),
    .out_saturation (out_saturation),
    .out_match      (out_match),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic hsl_word_t predict_hsl(logic [15:0] px);
    int r, g, b, mx, mn, dif, sum, l, h, s, lo, hi;
    bit hue_ok;
    hsl_word_t w;
    r = int'(px[15:11]) * 8;
    g = int'(px[10:5]) * 4;
    b = int'(px[4:0]) * 8;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dif = mx - mn;
    sum = mx + mn;
    l = sum * 240 / 255 / 2;
    h = 0;
    s = 0;
    // signed divides truncate toward zero; red wins max ties, then green
    if (dif != 0) begin
      if (mx == r) begin
        if (mn == b) h = 40 * (g - b) / dif;
        else h = 40 * (g - b) / dif + 240;
      end else if (mx == g) begin
        h = 40 * (b - r) / dif + 80;
      end else begin
        h = 40 * (r - g) / dif + 160;
      end
      if (l == 0) s = 0;
      else if (l <= 120) s = dif * 240 / sum;
      else s = dif * 240 / (511 - sum);
    end
    lo = int'(hue_low_q);
    hi = int'(hue_high_q);
    if (h > lo && h < hi) hue_ok = 1'b1;
    else if (hi < lo) hue_ok = (h < hi) || (h > lo - 65295);
    else if (hi > 240) hue_ok = (h > hi) || (h < hi - 240);
    else hue_ok = 1'b0;
    w.pixel      = px;
    w.hue        = h[7:0];
    w.lightness  = l[7:0];
    w.saturation = s[7:0];
    w.in_range   = l > int'(light_low_q) && l < int'(light_high_q) &&
                   s > int'(sat_low_q) && s < int'(sat_high_q) && hue_ok;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HUE_LOW:    hue_low_q = data;
      REG_HUE_HIGH:   hue_high_q = data;
      REG_SAT_LOW:    sat_low_q = data[7:0];
      REG_SAT_HIGH:   sat_high_q = data[7:0];
      REG_LIGHT_LOW:  light_low_q = data[7:0];
      REG_LIGHT_HIGH: light_high_q = data[7:0];
      default: ;
    endcase
  endtask

  // upper byte of the 8-bit registers gets junk, the block must mask it
  task automatic set_thresholds(logic [15:0] hl, logic [15:0] hh, logic [7:0] sl,
                                logic [7:0] sh, logic [7:0] ll, logic [7:0] lh);
    write_reg(REG_HUE_LOW, hl);
    write_reg(REG_HUE_HIGH, hh);
    write_reg(REG_SAT_LOW, {8'($urandom()), sl});
    write_reg(REG_SAT_HIGH, {8'($urandom()), sh});
    write_reg(REG_LIGHT_LOW, {8'($urandom()), ll});
    write_reg(REG_LIGHT_HIGH, {8'($urandom()), lh});
  endtask

  task automatic queue_directed();
    for (int i = N_DIRECTED - 1; i >= 0; i--) pixel_q.push_back(DIRECTED_PX[i*16 +: 16]);
  endtask

  // mix of uniform, dark and near-grey pixels
  task automatic queue_random(int n);
    logic [4:0] v;
    repeat (n) begin
      v = 5'($urandom_range(1, 30));
      case ($urandom_range(0, 3))
        0, 1: pixel_q.push_back(16'($urandom()));
        2: pixel_q.push_back({2'b00, 3'($urandom()), 3'b000, 3'($urandom()),
                              2'b00, 3'($urandom())});
        default: pixel_q.push_back({v ^ 5'($urandom_range(0, 1)),
                                    {v, 1'($urandom())} ^ 6'($urandom_range(0, 3)),
                                    v ^ 5'($urandom_range(0, 1))});
      endcase
    end
  endtask

  // wait until every queued pixel is taken and every word is back
  task automatic drain();
    @(posedge clk);
    while (pixel_q.size() != 0 || start) @(posedge clk);
    while (hsl_expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!start || in_took) begin
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_pixel <= pixel_q.pop_front();
        start    <= 1'b1;
      end else begin
        in_pixel <= 16'($urandom());
        start    <= 1'b0;
      end
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    hsl_word_t want;
    in_took <= rst_n && start && !busy;
    if (rst_n && start && !busy) hsl_expected_q.push_back(predict_hsl(in_pixel));
    if (rst_n && out_valid) begin
      if (hsl_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word hue=%0d light=%0d sat=%0d match=%0b",
                                  out_hue, out_lightness, out_saturation, out_match));
      end else begin
        want = hsl_expected_q.pop_front();
        if (out_hue !== want.hue || out_lightness !== want.lightness ||
            out_saturation !== want.saturation || out_match !== want.in_range)
          report_mismatch($sformatf(
            "px=%h got h/l/s/m=%0d/%0d/%0d/%0b want %0d/%0d/%0d/%0b",
            want.pixel, out_hue, out_lightness, out_saturation, out_match,
            want.hue, want.lightness, want.saturation, want.in_range));
      end
    end
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb565_hsl_color_classifier_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] hl, hh;
    logic [7:0]  sl, sh, ll, lh;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset thresholds: wrapped hue window around red, dark mid-saturation
    idle_pct = 0;
    queue_directed();
    queue_random(60);
    drain();

    // every range empty, low extreme
    set_thresholds(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    idle_pct = 54;
    queue_directed();
    queue_random(30);
    drain();

    // all bounds at the high extreme; saturation and lightness ranges empty
    set_thresholds(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    idle_pct = 8;
    queue_directed();
    queue_random(30);
    drain();

    // wide open; also poke the unused indexes
    set_thresholds(16'd0, 16'd241, 8'd0, 8'd255, 8'd0, 8'd255);
    write_reg(REG_SPARE_LO, 16'($urandom()));
    write_reg(REG_SPARE_HI, 16'($urandom()));
    idle_pct = 0;
    queue_random(80);
    drain();

    // upper bound above 240 turns on the low-end wrap; sender pauses midway
    set_thresholds(16'd200, 16'd280, 8'd20, 8'd240, 8'd10, 8'd200);
    idle_pct = 54;
    queue_random(100);
    drain();
    queue_random(100);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 2))
        0: hl = 16'($urandom_range(0, 240));
        1: hl = 16'($urandom_range(65295, 65535));
        default: hl = 16'($urandom());
      endcase
      case ($urandom_range(0, 2))
        0: hh = 16'($urandom_range(0, 240));
        1: hh = 16'($urandom_range(241, 480));
        default: hh = 16'($urandom());
      endcase
      sl = 8'($urandom_range(0, 120));
      sh = 8'($urandom_range(sl, 255));
      ll = 8'($urandom_range(0, 100));
      lh = 8'($urandom_range(ll, 255));
      set_thresholds(hl, hh, sl, sh, ll, lh);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 54 : 8;
      queue_random(100);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("rgb565_hsl_color_classifier_test passed");
    end else begin
      $display("rgb565_hsl_color_classifier_test failed");
    end
    $finish;
  end

endmodule
